@@ rtl/hkrs_pkg.sv @@
// Package of the housekeeping report scheduler: table depth, derived widths,
// status and request codes, configuration register indexes, and the status
// struct of the remainder unit. No dependencies.
package hkrs_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Result status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
	localparam logic [2:0] ST_UNEXPECTED  = 3'd2;
	localparam logic [2:0] ST_UNAVAILABLE = 3'd3;
	localparam logic [2:0] ST_INVALID     = 3'd4;

	// Request codes.
	localparam logic [2:0] RQ_LOAD    = 3'd0;
	localparam logic [2:0] RQ_START   = 3'd1;
	localparam logic [2:0] RQ_TICK    = 3'd2;
	localparam logic [2:0] RQ_ENABLE  = 3'd3;
	localparam logic [2:0] RQ_DISABLE = 3'd4;
	localparam logic [2:0] RQ_SETRATE = 3'd5;
	localparam logic [2:0] RQ_DUMP    = 3'd6;

	// Configuration register indexes.
	localparam logic CFG_TABLE_SIZE     = 1'b0;
	localparam logic CFG_FRAME_OVERHEAD = 1'b1;

	// Status of the iterative remainder unit.
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} mod_stat_t;

endpackage

@@ rtl/hkrs_if.sv @@
// Valid/ready channel interfaces for requests and results of the
// housekeeping report scheduler. No dependencies.
interface hkrs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [4:0]  entry_index;
	logic [15:0] hk_id;
	logic [15:0] rate_value;
	logic        enable_value;
	logic [15:0] packet_length;

	modport source (output valid, req_type, entry_index, hk_id, rate_value,
		enable_value, packet_length, input ready);
	modport sink (input valid, req_type, entry_index, hk_id, rate_value,
		enable_value, packet_length, output ready);
endinterface

interface hkrs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] report_id;
	logic [15:0] report_rate;
	logic        report_enabled;
	logic        is_report;
	logic        last;

	modport source (output valid, status, report_id, report_rate,
		report_enabled, is_report, last, input ready);
	modport sink (input valid, status, report_id, report_rate,
		report_enabled, is_report, last, output ready);
endinterface

@@ rtl/housekeeping_report_scheduler_unit.sv @@
// Top level of the housekeeping report scheduler: table memories, command
// sequencer and result register. Depends on hkrs_pkg, hkrs_if, hkrs_mod_unit.
//
// Use: requests arrive on the req channel, results leave on the rsp channel;
// both transfer when valid and ready are high at a rising edge. Registers
// table_size (index 0) and frame_overhead (index 1) are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Every request but
// tick, and a tick before a successful start, gives one response with last set.
// Otherwise a tick gives one report per due entry, the final one with last
// set, or none at all. Start checks the table entries in order; enable or
// disable of all entries sweeps over every entry in use. Enable, disable,
// set-rate and dump of one id look up the entry by binary search. A tick
// reads each entry in turn and, for one enabled with a nonzero rate, waits
// on the bit-serial remainder unit. One request is worked on at a time;
// req.ready is high only while the sequencer is idle.
// A finished result waits in the output register; while the receiver stalls
// the sequencer holds at its next result, and a new request is taken as soon
// as the last result is in the register.
// Reset clears the tick count, the initialized flag and both registers; the
// table contents stay undefined until loaded, and no clearing pass is run.
module housekeeping_report_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	hkrs_req_if.sink    req,
	hkrs_rsp_if.source  rsp
);

	localparam int IW = hkrs_pkg::IDX_W;
	localparam int CW = hkrs_pkg::CNT_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RESP  = 4'd1;
	localparam logic [3:0] S_VRD   = 4'd2;
	localparam logic [3:0] S_VCK   = 4'd3;
	localparam logic [3:0] S_TRD   = 4'd4;
	localparam logic [3:0] S_TCK   = 4'd5;
	localparam logic [3:0] S_TMOD  = 4'd6;
	localparam logic [3:0] S_TDUE  = 4'd7;
	localparam logic [3:0] S_TEND  = 4'd8;
	localparam logic [3:0] S_SRD   = 4'd9;
	localparam logic [3:0] S_SCK   = 4'd10;
	localparam logic [3:0] S_SWEEP = 4'd11;

	// Table memories: id and rate together, enable bit apart.
	logic [31:0] ir_mem [hkrs_pkg::TABLE_DEPTH];
	logic        en_mem [hkrs_pkg::TABLE_DEPTH];

	logic [3:0]  state_q;
	logic        init_q;
	logic [31:0] cnt_q;
	logic [5:0]  tsize_q;
	logic [15:0] fo_q;
	logic [2:0]  typ_q;
	logic [15:0] id_q;
	logic [15:0] rate_q;
	logic [CW-1:0] i_q;
	logic signed [CW:0] lo_q;
	logic signed [CW:0] hi_q;
	logic [IW-1:0] mid_q;
	logic [15:0] prev_id_q;
	logic [2:0]  resp_st_q;
	logic [15:0] resp_id_q;
	logic [15:0] resp_rate_q;
	logic        resp_en_q;
	logic        pend_v_q;
	logic [15:0] pend_id_q;
	logic [15:0] pend_rate_q;
	logic        rsp_valid_q;

	logic [15:0] rd_id_q;
	logic [15:0] rd_rate_q;
	logic        rd_en_q;

	logic          rd_req;
	logic [IW-1:0] rd_addr;
	logic          ir_we;
	logic [IW-1:0] ir_addr;
	logic [31:0]   ir_data;
	logic          en_we;
	logic [IW-1:0] en_addr;
	logic          en_data;
	logic          push;
	logic [2:0]    push_st;
	logic [15:0]   push_id;
	logic [15:0]   push_rate;
	logic          push_en;
	logic          push_rep;
	logic          push_last;
	logic          mod_start;
	logic          out_free;
	logic [CW-1:0] n_used;
	logic signed [CW+1:0] mid_sum;
	logic signed [CW:0]   mid_full;
	logic [16:0]   plen;
	logic [16:0]   plen_need;
	logic          slot_ok;
	logic          len_ok;

	hkrs_pkg::mod_stat_t mod_stat;

	hkrs_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cnt_q),
		.divisor  (rd_rate_q),
		.stat     (mod_stat)
	);

	// Entries in use, clipped to the table depth.
	assign n_used = ({1'b0, tsize_q} > 7'(hkrs_pkg::TABLE_DEPTH)) ?
		CW'(hkrs_pkg::TABLE_DEPTH) : CW'(tsize_q);

	assign mid_sum  = (CW+2)'(lo_q) + (CW+2)'(hi_q);
	assign mid_full = (CW+1)'(mid_sum >>> 1);

	assign out_free = !rsp_valid_q || rsp.ready;

	// Length check of telecommands against the frame overhead.
	assign plen      = {1'b0, req.packet_length} + 17'd1;
	assign plen_need = {1'b0, fo_q} +
		((req.req_type == hkrs_pkg::RQ_SETRATE) ? 17'd4 : 17'd2);
	assign len_ok    = (plen == plen_need);
	assign slot_ok   = (32'(req.entry_index) < 32'(hkrs_pkg::TABLE_DEPTH));

	assign req.ready = (state_q == S_IDLE);

	// Memory accesses, result pushes and remainder starts per state.
	always_comb begin
		rd_req    = 1'b0;
		rd_addr   = IW'(i_q);
		ir_we     = 1'b0;
		ir_addr   = IW'(req.entry_index);
		ir_data   = {req.hk_id, req.rate_value};
		en_we     = 1'b0;
		en_addr   = IW'(req.entry_index);
		en_data   = req.enable_value;
		push      = 1'b0;
		push_st   = resp_st_q;
		push_id   = resp_id_q;
		push_rate = resp_rate_q;
		push_en   = resp_en_q;
		push_rep  = 1'b0;
		push_last = 1'b1;
		mod_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.req_type == hkrs_pkg::RQ_LOAD && slot_ok) begin
					ir_we = 1'b1;
					en_we = 1'b1;
				end
			end
			S_VRD: rd_req = 1'b1;
			S_TRD: rd_req = (i_q != n_used);
			S_TCK: mod_start = rd_en_q && (rd_rate_q != 16'd0);
			S_SRD: begin
				rd_req  = (lo_q <= hi_q);
				rd_addr = IW'(mid_full);
			end
			S_SCK: begin
				if (rd_id_q == id_q) begin
					ir_addr = mid_q;
					ir_data = {rd_id_q, rate_q};
					en_addr = mid_q;
					en_data = (typ_q == hkrs_pkg::RQ_ENABLE);
					ir_we   = (typ_q == hkrs_pkg::RQ_SETRATE);
					en_we   = (typ_q == hkrs_pkg::RQ_ENABLE) ||
						(typ_q == hkrs_pkg::RQ_DISABLE);
				end
			end
			S_SWEEP: begin
				en_addr = IW'(i_q);
				en_data = (typ_q == hkrs_pkg::RQ_ENABLE);
				en_we   = (i_q != n_used);
			end
			S_RESP: push = out_free;
			S_TDUE, S_TEND: begin
				push      = pend_v_q && out_free;
				push_st   = hkrs_pkg::ST_OK;
				push_id   = pend_id_q;
				push_rate = pend_rate_q;
				push_en   = 1'b1;
				push_rep  = 1'b1;
				push_last = (state_q == S_TEND);
			end
			default: ;
		endcase
	end

	// Table memories with registered reads.
	always_ff @(posedge clk) begin
		if (ir_we) begin
			ir_mem[ir_addr] <= ir_data;
		end
		if (en_we) begin
			en_mem[en_addr] <= en_data;
		end
		if (rd_req) begin
			rd_id_q   <= ir_mem[rd_addr][31:16];
			rd_rate_q <= ir_mem[rd_addr][15:0];
			rd_en_q   <= en_mem[rd_addr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= 6'd0;
			fo_q    <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				hkrs_pkg::CFG_TABLE_SIZE:     tsize_q <= cfg_data[5:0];
				hkrs_pkg::CFG_FRAME_OVERHEAD: fo_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			init_q   <= 1'b0;
			cnt_q    <= 32'd0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						typ_q       <= req.req_type;
						id_q        <= req.hk_id;
						rate_q      <= req.rate_value;
						resp_id_q   <= 16'd0;
						resp_rate_q <= 16'd0;
						resp_en_q   <= 1'b0;
						i_q         <= '0;
						lo_q        <= '0;
						hi_q        <= (CW+1)'(n_used) - (CW+1)'(1);
						pend_v_q    <= 1'b0;
						state_q     <= S_RESP;
						case (req.req_type)
							hkrs_pkg::RQ_LOAD: begin
								resp_st_q <= slot_ok ? hkrs_pkg::ST_OK : hkrs_pkg::ST_UNEXPECTED;
							end
							hkrs_pkg::RQ_START: begin
								resp_st_q <= hkrs_pkg::ST_INVALID;
								if (n_used != '0) begin
									state_q <= S_VRD;
								end
							end
							hkrs_pkg::RQ_TICK: begin
								resp_st_q <= hkrs_pkg::ST_UNAVAILABLE;
								if (init_q) begin
									state_q <= S_TRD;
								end
							end
							hkrs_pkg::RQ_ENABLE, hkrs_pkg::RQ_DISABLE,
							hkrs_pkg::RQ_SETRATE, hkrs_pkg::RQ_DUMP: begin
								if (!len_ok) begin
									resp_st_q <= hkrs_pkg::ST_UNEXPECTED;
								end else if (!init_q) begin
									resp_st_q <= hkrs_pkg::ST_UNAVAILABLE;
								end else if (req.hk_id == 16'd0) begin
									if (req.req_type == hkrs_pkg::RQ_ENABLE ||
										req.req_type == hkrs_pkg::RQ_DISABLE) begin
										resp_st_q <= hkrs_pkg::ST_OK;
										state_q   <= S_SWEEP;
									end else begin
										resp_st_q <= hkrs_pkg::ST_UNEXPECTED;
									end
								end else if (req.req_type == hkrs_pkg::RQ_SETRATE &&
									req.rate_value == 16'd0) begin
									resp_st_q <= hkrs_pkg::ST_UNEXPECTED;
								end else begin
									state_q <= S_SRD;
								end
							end
							default: resp_st_q <= hkrs_pkg::ST_UNEXPECTED;
						endcase
					end
				end
				S_VRD: state_q <= S_VCK;
				S_VCK: begin
					if ((i_q == '0 && rd_id_q == 16'd0) || rd_rate_q == 16'd0 ||
						(i_q != '0 && rd_id_q <= prev_id_q)) begin
						resp_st_q <= hkrs_pkg::ST_INVALID;
						state_q   <= S_RESP;
					end else if (i_q + CW'(1) == n_used) begin
						init_q    <= 1'b1;
						cnt_q     <= 32'd0;
						resp_st_q <= hkrs_pkg::ST_OK;
						state_q   <= S_RESP;
					end else begin
						prev_id_q <= rd_id_q;
						i_q       <= i_q + CW'(1);
						state_q   <= S_VRD;
					end
				end
				S_TRD: state_q <= (i_q == n_used) ? S_TEND : S_TCK;
				S_TCK: begin
					if (rd_en_q && rd_rate_q != 16'd0) begin
						state_q <= S_TMOD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_TRD;
					end
				end
				S_TMOD: begin
					if (mod_stat.done) begin
						if (mod_stat.rem_zero) begin
							state_q <= S_TDUE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_TRD;
						end
					end
				end
				S_TDUE: begin
					// The held report goes out, the new one takes its place.
					if (!pend_v_q || out_free) begin
						pend_v_q    <= 1'b1;
						pend_id_q   <= rd_id_q;
						pend_rate_q <= rd_rate_q;
						i_q         <= i_q + CW'(1);
						state_q     <= S_TRD;
					end
				end
				S_TEND: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						cnt_q    <= cnt_q + 32'd1;
						state_q  <= S_IDLE;
					end
				end
				S_SRD: begin
					if (lo_q > hi_q) begin
						resp_st_q <= hkrs_pkg::ST_NOT_FOUND;
						state_q   <= S_RESP;
					end else begin
						mid_q   <= IW'(mid_full);
						state_q <= S_SCK;
					end
				end
				S_SCK: begin
					if (rd_id_q == id_q) begin
						resp_st_q <= hkrs_pkg::ST_OK;
						if (typ_q == hkrs_pkg::RQ_DUMP) begin
							resp_id_q   <= rd_id_q;
							resp_rate_q <= rd_rate_q;
							resp_en_q   <= rd_en_q;
						end
						state_q <= S_RESP;
					end else begin
						if (rd_id_q < id_q) begin
							lo_q <= (CW+1)'(mid_q) + (CW+1)'(1);
						end else begin
							hi_q <= (CW+1)'(mid_q) - (CW+1)'(1);
						end
						state_q <= S_SRD;
					end
				end
				S_SWEEP: begin
					if (i_q == n_used) begin
						state_q <= S_RESP;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp.status         <= push_st;
			rsp.report_id      <= push_id;
			rsp.report_rate    <= push_rate;
			rsp.report_enabled <= push_en;
			rsp.is_report      <= push_rep;
			rsp.last           <= push_last;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

@@ rtl/hkrs_mod_unit.sv @@
// Restoring remainder unit: 32-bit dividend modulo 16-bit divisor, one
// quotient bit per cycle. Depends on hkrs_pkg.
module hkrs_mod_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        dividend,
	input  logic [15:0]        divisor,
	output hkrs_pkg::mod_stat_t stat
);

	logic [15:0] rem_q;
	logic [31:0] dvd_q;
	logic [15:0] div_q;
	logic [5:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;

	// Shift in the next dividend bit and subtract when it fits.
	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= 6'd32;
		end else if (busy_q) begin
			step_q <= step_q - 6'd1;
			if (step_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath needs no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 16'd0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 16'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[15:0];
			end
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == 16'd0);

endmodule

@@ rtl/hkrs_checker.sv @@
// Port-level checker of the housekeeping report scheduler and its bind to
// the top level. Depends on hkrs_pkg and housekeeping_report_scheduler_unit.
module hkrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] report_id,
	input logic        report_enabled,
	input logic        is_report,
	input logic        last
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(report_id) && $stable(status))
		else $error("stalled result changed");

	// One request at a time: after a transfer the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// A command response is always the only result of its request.
	a_resp_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_report |-> last)
		else $error("command response without last");

	// A tick report is always good and enabled.
	a_report_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_report |-> status == hkrs_pkg::ST_OK && report_enabled)
		else $error("bad tick report");

endmodule

bind housekeeping_report_scheduler_unit hkrs_checker u_hkrs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.status         (rsp.status),
	.report_id      (rsp.report_id),
	.report_enabled (rsp.report_enabled),
	.is_report      (rsp.is_report),
	.last           (rsp.last)
);
